@@ hw/rtl/b64d_pkg.sv @@
// Shared types and constants for the Base64 stream decoder.
package b64d_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharSlash   = 8'h2F;
  localparam logic [7:0] CharPad     = 8'h3D;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusInvalid = 2'd1,
    StatusLength  = 2'd2,
    StatusPadding = 2'd3
  } status_e;

  // One job for the back end: up to three decoded bytes, then an optional
  // closing word that carries the message status.
  typedef struct packed {
    logic [23:0] bytes;
    logic [1:0]  nbytes;
    logic        close;
    status_e     status;
  } job_t;

endpackage

@@ hw/rtl/b64d_if.sv @@
// Valid/ready stream interfaces for the text input and the decoded output.
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       final_char;

  modport source (output valid, output text_char, output final_char, input ready);
  modport sink   (input valid, input text_char, input final_char, output ready);
endinterface

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       message_end;
  logic [1:0] status;

  modport source (output valid, output data_byte, output byte_valid,
                  output message_end, output status, input ready);
  modport sink   (input valid, input data_byte, input byte_valid,
                  input message_end, input status, output ready);
endinterface

@@ hw/rtl/b64d_front.sv @@
// Front end: classifies characters, assembles groups and emits jobs.
module b64d_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [7:0]       text_char_i,
  input  logic             final_char_i,
  input  logic             fifo_full_i,
  output logic             ready_o,
  output logic             push_o,
  output b64d_pkg::job_t   job_o
);
  import b64d_pkg::*;

  logic [17:0] sextet_q, sextet_d;
  logic [1:0]  pos_q, pos_d;
  logic        pad_q, pad_d;
  status_e     err_q, err_d;

  logic        accept;
  logic        is_ws;
  logic        is_pad;
  logic        char_ok;
  logic [5:0]  char_val;
  logic [5:0]  sextet;
  logic [23:0] full_group;
  logic [1:0]  nbytes;
  status_e     close_status;

  always_comb begin
    char_ok  = 1'b1;
    char_val = '0;
    if (text_char_i inside {[8'h41:8'h5A]}) begin
      char_val = 6'(text_char_i - 8'h41);
    end else if (text_char_i inside {[8'h61:8'h7A]}) begin
      char_val = 6'(text_char_i - 8'h61 + 8'd26);
    end else if (text_char_i inside {[8'h30:8'h39]}) begin
      char_val = 6'(text_char_i - 8'h30 + 8'd52);
    end else if (text_char_i == CharPlus) begin
      char_val = 6'd62;
    end else if (text_char_i == CharSlash) begin
      char_val = 6'd63;
    end else begin
      char_ok = 1'b0;
    end
  end

  assign ready_o    = !fifo_full_i;
  assign accept     = valid_i && ready_o;
  assign is_ws      = (text_char_i == CharSpace) || (text_char_i == CharNewline);
  assign is_pad     = (text_char_i == CharPad);
  assign sextet     = (is_pad || pad_q) ? 6'd0 : char_val;
  assign full_group = {sextet_q, sextet};

  always_comb begin
    sextet_d     = sextet_q;
    pos_d        = pos_q;
    pad_d        = pad_q;
    err_d        = err_q;
    nbytes       = 2'd0;
    close_status = StatusOk;

    if (accept) begin
      if (!is_ws && err_q == StatusOk) begin
        if (!is_pad && !char_ok) begin
          err_d = StatusInvalid;
        end else if (pos_q == 2'd0) begin
          // A group may not open with padding or follow a padded group.
          if (is_pad || pad_q) begin
            err_d = StatusPadding;
          end else begin
            sextet_d = {12'd0, char_val};
            pos_d    = 2'd1;
          end
        end else if (pos_q != 2'd3) begin
          sextet_d = {sextet_q[11:0], sextet};
          if (is_pad) pad_d = 1'b1;
          pos_d = pos_q + 2'd1;
        end else begin
          if (pad_q) begin
            nbytes = 2'd1;
          end else if (is_pad) begin
            nbytes = 2'd2;
          end else begin
            nbytes = 2'd3;
          end
          if (is_pad) pad_d = 1'b1;
          sextet_d = '0;
          pos_d    = 2'd0;
        end
      end

      if (final_char_i) begin
        close_status = (err_d == StatusOk && pos_d != 2'd0) ? StatusLength : err_d;
        sextet_d = '0;
        pos_d    = 2'd0;
        pad_d    = 1'b0;
        err_d    = StatusOk;
      end
    end
  end

  assign push_o       = accept && (nbytes != 2'd0 || final_char_i);
  assign job_o.bytes  = full_group;
  assign job_o.nbytes = nbytes;
  assign job_o.close  = final_char_i;
  assign job_o.status = close_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sextet_q <= '0;
      pos_q    <= 2'd0;
      pad_q    <= 1'b0;
      err_q    <= StatusOk;
    end else begin
      sextet_q <= sextet_d;
      pos_q    <= pos_d;
      pad_q    <= pad_d;
      err_q    <= err_d;
    end
  end

endmodule

@@ hw/rtl/b64d_fifo.sv @@
// Short job queue between the front end and the back end.
module b64d_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64d_pkg::job_t data_i,
  input  logic           pop_i,
  output b64d_pkg::job_t data_o,
  output logic           full_o,
  output logic           empty_o
);
  import b64d_pkg::*;

  job_t                mem_q [FifoDepth];
  logic [FifoAw-1:0]   wr_ptr_q;
  logic [FifoAw-1:0]   rd_ptr_q;
  logic [FifoAw:0]     count_q;

  assign full_o  = (count_q == (FifoAw+1)'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/b64d_back.sv @@
// Back end: plays out each job as byte words and, if the job closes a message, a closing word.
module b64d_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  b64d_pkg::job_t job_i,
  input  logic           fifo_empty_i,
  output logic           pop_o,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [7:0]     data_byte_o,
  output logic           byte_valid_o,
  output logic           message_end_o,
  output logic [1:0]     status_o
);
  import b64d_pkg::*;

  job_t       cur_q;
  logic       busy_q;
  logic [1:0] idx_q;
  logic [2:0] total;
  logic       last;
  logic       out_accept;
  logic       is_byte;
  logic [7:0] sel_byte;

  assign total      = {1'b0, cur_q.nbytes} + {2'b0, cur_q.close};
  assign last       = ({1'b0, idx_q} + 3'd1) == total;
  assign out_accept = busy_q && ready_i;
  assign pop_o      = !fifo_empty_i && (!busy_q || (out_accept && last));
  assign is_byte    = idx_q < cur_q.nbytes;

  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = cur_q.bytes[23:16];
      2'd1:    sel_byte = cur_q.bytes[15:8];
      default: sel_byte = cur_q.bytes[7:0];
    endcase
  end

  assign valid_o       = busy_q;
  assign data_byte_o   = is_byte ? sel_byte : 8'd0;
  assign byte_valid_o  = is_byte;
  assign message_end_o = !is_byte;
  assign status_o      = is_byte ? StatusOk : cur_q.status;

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= 2'd0;
    end else if (out_accept) begin
      if (last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

endmodule

@@ hw/rtl/base64_stream_decoder_core.sv @@
// Base64 stream decoder: one character accepted per cycle when the queue has room.
// A completed group goes through the job queue and the back end's job register before
// its first byte shows; a job emits one word per cycle while ready, up to four words.
// Throughput: one character per cycle, limited by output backpressure and the
// four-entry job queue. Reset clears group state, queue and output control.
module base64_stream_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  b64d_in_if.sink    in_i,
  b64d_out_if.source out_o
);
  import b64d_pkg::*;

  job_t push_job;
  job_t head_job;
  logic push;
  logic pop;
  logic full;
  logic empty;

  b64d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_i.valid),
    .text_char_i  (in_i.text_char),
    .final_char_i (in_i.final_char),
    .fifo_full_i  (full),
    .ready_o      (in_i.ready),
    .push_o       (push),
    .job_o        (push_job)
  );

  b64d_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .pop_i   (pop),
    .data_o  (head_job),
    .full_o  (full),
    .empty_o (empty)
  );

  b64d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (head_job),
    .fifo_empty_i  (empty),
    .pop_o         (pop),
    .valid_o       (out_o.valid),
    .ready_i       (out_o.ready),
    .data_byte_o   (out_o.data_byte),
    .byte_valid_o  (out_o.byte_valid),
    .message_end_o (out_o.message_end),
    .status_o      (out_o.status)
  );

endmodule
